@@ rtl/circular_fifo_queue_top_assert.svh @@
// Assertion macros shared by the FIFO queue checker.
`ifndef CIRCULAR_FIFO_QUEUE_TOP_ASSERT_SVH
`define CIRCULAR_FIFO_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled in reset.
`define CFQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("circular_fifo_queue: assertion failed");

// Next-cycle implication, sampled on clk and disabled in reset.
`define CFQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("circular_fifo_queue: assertion failed");

`endif

@@ rtl/cfq_pkg.sv @@
// Package with the command, status and state types of the FIFO queue.
package cfq_pkg;

  localparam int MAX_RESULTS = 16;
  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam int WORD_W = 32;

  typedef enum logic [1:0] {
    CMD_ENQ   = 2'd0,
    CMD_DEQ   = 2'd1,
    CMD_PEEK  = 2'd2,
    CMD_PRINT = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_READ = 2'd1,
    S_SEND = 2'd2
  } state_t;

endpackage

@@ rtl/cfq_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module cfq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/circular_fifo_queue_top.sv @@
// Top level of the ring-buffer FIFO queue of signed 32-bit words.
// One command is taken at a time. The block stalls its input until every result
// beat of that command has been taken. An enqueue, and any command on an empty
// queue, gives its result in the cycle after acceptance. A dequeue or a peek
// first passes through a read state for the slot RAM. A print walks the stored
// words from oldest to newest, at most 16 of them; each beat passes through a
// read state and a send state held by output stalls, because each beat waits for
// its own RAM read. A write to the capacity register empties the queue. The slot
// RAM is never cleared: only slots that hold stored words are read.
module circular_fifo_queue_top #(
  parameter int DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [cfq_pkg::CAP_W-1:0]           cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          cmd,
  input  logic signed [cfq_pkg::WORD_W-1:0]   value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          status,
  output logic signed [cfq_pkg::WORD_W-1:0]   data,
  output logic                                last
);

  localparam int AddrW = $clog2(DEPTH);
  localparam int CntW  = $clog2(DEPTH + 1);
  localparam int RemW  = $clog2(cfq_pkg::MAX_RESULTS);

  cfq_pkg::state_t              state, state_next;
  cfq_pkg::status_t             status_q;
  cfq_pkg::cmd_t                cmd_in;
  logic [cfq_pkg::CAP_W-1:0]    capacity;
  logic [CntW-1:0]              cap_eff;
  logic [AddrW-1:0]             head, tail, ptr;
  logic [CntW-1:0]              occupancy;
  logic [RemW-1:0]              remaining;
  logic                         use_mem;
  logic                         in_acc, out_acc, full;
  logic                         ram_wr_en, ram_rd_en;
  logic [cfq_pkg::WORD_W-1:0]   ram_q;

  function automatic logic [AddrW-1:0] advance(input logic [AddrW-1:0] idx,
                                               input logic [CntW-1:0] lim);
    logic [CntW-1:0] n;
    n = CntW'(idx) + CntW'(1);
    return (n >= lim) ? '0 : idx + AddrW'(1);
  endfunction

  assign cmd_in  = cfq_pkg::cmd_t'(cmd);
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign full    = (occupancy >= cap_eff);

  always_comb begin
    if (capacity == '0) begin
      cap_eff = CntW'(1);
    end else if (32'(capacity) > DEPTH) begin
      cap_eff = CntW'(DEPTH);
    end else begin
      cap_eff = CntW'(capacity);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      cfq_pkg::S_IDLE: begin
        if (in_acc) begin
          if (cmd_in == cfq_pkg::CMD_ENQ || occupancy == '0) begin
            state_next = cfq_pkg::S_SEND;
          end else begin
            state_next = cfq_pkg::S_READ;
          end
        end
      end
      cfq_pkg::S_READ: state_next = cfq_pkg::S_SEND;
      cfq_pkg::S_SEND: begin
        if (out_acc) begin
          state_next = (remaining == '0) ? cfq_pkg::S_IDLE : cfq_pkg::S_READ;
        end
      end
      default: state_next = cfq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != cfq_pkg::S_IDLE);
    out_valid = (state == cfq_pkg::S_SEND);
    ram_rd_en = (state == cfq_pkg::S_READ);
    ram_wr_en = in_acc && (cmd_in == cfq_pkg::CMD_ENQ) && !full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cfq_pkg::S_IDLE;
      capacity  <= cfq_pkg::CAP_RESET;
      head      <= '0;
      tail      <= '0;
      occupancy <= '0;
      remaining <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        capacity  <= cfg_wr_data;
        head      <= '0;
        tail      <= '0;
        occupancy <= '0;
      end else if (in_acc) begin
        remaining <= '0;
        use_mem   <= 1'b0;
        ptr       <= head;
        case (cmd_in)
          cfq_pkg::CMD_ENQ: begin
            if (full) begin
              status_q <= cfq_pkg::ST_FULL;
            end else begin
              status_q  <= cfq_pkg::ST_OK;
              tail      <= advance(tail, cap_eff);
              occupancy <= occupancy + CntW'(1);
            end
          end
          cfq_pkg::CMD_DEQ: begin
            if (occupancy == '0) begin
              status_q <= cfq_pkg::ST_EMPTY;
            end else begin
              status_q  <= cfq_pkg::ST_OK;
              use_mem   <= 1'b1;
              occupancy <= occupancy - CntW'(1);
              if (occupancy == CntW'(1)) begin
                head <= '0;
                tail <= '0;
              end else begin
                head <= advance(head, cap_eff);
              end
            end
          end
          cfq_pkg::CMD_PEEK: begin
            if (occupancy == '0) begin
              status_q <= cfq_pkg::ST_EMPTY;
            end else begin
              status_q <= cfq_pkg::ST_OK;
              use_mem  <= 1'b1;
            end
          end
          cfq_pkg::CMD_PRINT: begin
            if (occupancy == '0) begin
              status_q <= cfq_pkg::ST_EMPTY;
            end else begin
              status_q <= cfq_pkg::ST_OK;
              use_mem  <= 1'b1;
              if (32'(occupancy) > cfq_pkg::MAX_RESULTS) begin
                remaining <= RemW'(cfq_pkg::MAX_RESULTS - 1);
              end else begin
                remaining <= RemW'(occupancy - CntW'(1));
              end
            end
          end
          default: status_q <= cfq_pkg::ST_EMPTY;
        endcase
      end else if (out_acc && remaining != '0) begin
        ptr       <= advance(ptr, cap_eff);
        remaining <= remaining - RemW'(1);
      end
    end
  end

  cfq_ram #(
    .WIDTH (cfq_pkg::WORD_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (tail),
    .wr_data (value),
    .rd_en   (ram_rd_en),
    .rd_addr (ptr),
    .rd_data (ram_q)
  );

  assign status = status_q;
  assign data   = use_mem ? $signed(ram_q) : '0;
  assign last   = (remaining == '0);

endmodule

@@ rtl/cfq_checker.sv @@
// Port-level checker for the FIFO queue, bound to the top level.
`include "circular_fifo_queue_top_assert.svh"

module cfq_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              cfg_wr_en,
  input logic [cfq_pkg::CAP_W-1:0]         cfg_wr_data,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic [1:0]                        cmd,
  input logic signed [cfq_pkg::WORD_W-1:0] value,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [1:0]                        status,
  input logic signed [cfq_pkg::WORD_W-1:0] data,
  input logic                              last
);

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  `CFQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(data) && $stable(status) && $stable(last))
  `CFQ_ASSERT_NOW(a_busy_while_result, out_valid, in_stall)
  `CFQ_ASSERT_NEXT(a_one_command_at_once, in_acc, in_stall)
  `CFQ_ASSERT_NEXT(a_enq_result, in_acc && cmd == cfq_pkg::CMD_ENQ, out_valid && last && data == '0)

endmodule

bind circular_fifo_queue_top cfq_checker u_cfq_checker (.*);
